### rtl/idq_pkg.sv
// Package for the indexed double-ended queue: sizes, beat layouts, op and status codes.
// Shared result and memory-request types. No dependencies.
`default_nettype none

package idq_pkg;

  // CAPACITY must be a power of two; the ring slot wraps by truncation.
  localparam int CAPACITY = 1024;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = PTR_W + 1;
  localparam int DATA_W   = 32;
  localparam int VALUE_W  = 32;

  localparam int IN_TDATA_W  = ((CNT_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VALUE_W + CNT_W + 1 + 7) / 8) * 8;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd5;
  localparam logic [OP_W-1:0] OP_ERASE      = 3'd6;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data;
    logic [CNT_W-1:0]    count;
    logic                is_empty;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } ram_req_t;

endpackage

`default_nettype wire

### rtl/idq_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module idq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/idq_ctrl.sv
// Sequencer for the queue: head/count registers, op decode, read-modify-write
// of the ring store and the shift loop for middle insert and erase. Uses idq_pkg.
`default_nettype none

module idq_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [idq_pkg::OP_W-1:0]          in_op,
  input  wire logic [idq_pkg::CNT_W-1:0]         in_index,
  input  wire logic [idq_pkg::VALUE_W-1:0]       in_value,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output idq_pkg::res_t                          res,
  output idq_pkg::ram_req_t                      ram_req,
  input  wire logic [idq_pkg::DATA_W-1:0]        ram_rdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDW   = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_INSW  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  localparam logic [idq_pkg::CNT_W-1:0] FULL_CNT = idq_pkg::CNT_W'(idq_pkg::CAPACITY);
  localparam logic [idq_pkg::CNT_W-1:0] ONE_CNT  = idq_pkg::CNT_W'(1);
  localparam logic [idq_pkg::PTR_W-1:0] ONE_PTR  = idq_pkg::PTR_W'(1);

  logic [2:0]                        state_r, state_nxt;
  logic [idq_pkg::PTR_W-1:0]         head_r, head_nxt;
  logic [idq_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [idq_pkg::OP_W-1:0]          op_r, op_nxt;
  logic [idq_pkg::CNT_W-1:0]         idx_r, idx_nxt;
  logic [idq_pkg::DATA_W-1:0]        val_r, val_nxt;
  logic [idq_pkg::CNT_W-1:0]         src_r, src_nxt;
  logic                              pend_r, pend_nxt;
  logic [idq_pkg::PTR_W-1:0]         pdst_r, pdst_nxt;
  logic [idq_pkg::STATUS_W-1:0]      status_r, status_nxt;
  logic [idq_pkg::DATA_W-1:0]        data_r, data_nxt;
  logic                              full, empty;

  function automatic logic [idq_pkg::PTR_W-1:0] slot_of(
    input logic [idq_pkg::PTR_W-1:0] head,
    input logic [idq_pkg::CNT_W-1:0] logical
  );
    return head + logical[idq_pkg::PTR_W-1:0];
  endfunction

  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);
  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);

  always_comb begin
    res.status   = status_r;
    res.data     = idq_pkg::VALUE_W'(data_r);
    res.count    = count_r;
    res.is_empty = empty;
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    op_nxt     = op_r;
    idx_nxt    = idx_r;
    val_nxt    = val_r;
    src_nxt    = src_r;
    pend_nxt   = pend_r;
    pdst_nxt   = pdst_r;
    status_nxt = status_r;
    data_nxt   = data_r;
    ram_req    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          idx_nxt    = in_index;
          val_nxt    = in_value[idq_pkg::DATA_W-1:0];
          status_nxt = idq_pkg::ST_OK;
          data_nxt   = '0;
          state_nxt  = S_RESP;
          case (in_op)
            idq_pkg::OP_PUSH_BACK: begin
              if (full) begin
                status_nxt = idq_pkg::ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = slot_of(head_r, count_r);
                ram_req.wdata = in_value[idq_pkg::DATA_W-1:0];
                count_nxt     = count_r + ONE_CNT;
              end
            end
            idq_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                status_nxt = idq_pkg::ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = head_r - ONE_PTR;
                ram_req.wdata = in_value[idq_pkg::DATA_W-1:0];
                head_nxt      = head_r - ONE_PTR;
                count_nxt     = count_r + ONE_CNT;
              end
            end
            idq_pkg::OP_POP_BACK: begin
              if (empty) begin
                status_nxt = idq_pkg::ST_EMPTY;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = slot_of(head_r, count_r - ONE_CNT);
                state_nxt     = S_RDW;
              end
            end
            idq_pkg::OP_POP_FRONT: begin
              if (empty) begin
                status_nxt = idq_pkg::ST_EMPTY;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = head_r;
                state_nxt     = S_RDW;
              end
            end
            idq_pkg::OP_READ: begin
              if (in_index >= count_r) begin
                status_nxt = idq_pkg::ST_RANGE;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = slot_of(head_r, in_index);
                state_nxt     = S_RDW;
              end
            end
            idq_pkg::OP_INSERT: begin
              if (in_index > count_r) begin
                status_nxt = idq_pkg::ST_RANGE;
              end else if (full) begin
                status_nxt = idq_pkg::ST_FULL;
              end else if (in_index == count_r) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = slot_of(head_r, count_r);
                ram_req.wdata = in_value[idq_pkg::DATA_W-1:0];
                count_nxt     = count_r + ONE_CNT;
              end else begin
                src_nxt   = count_r - ONE_CNT;
                pend_nxt  = 1'b0;
                state_nxt = S_SHIFT;
              end
            end
            idq_pkg::OP_ERASE: begin
              if (empty) begin
                status_nxt = idq_pkg::ST_EMPTY;
              end else if (in_index >= count_r) begin
                status_nxt = idq_pkg::ST_RANGE;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = slot_of(head_r, in_index);
                state_nxt     = S_RDW;
              end
            end
            default: begin
              count_nxt = '0;
              head_nxt  = '0;
            end
          endcase
        end
      end

      S_RDW: begin
        data_nxt  = ram_rdata;
        state_nxt = S_RESP;
        case (op_r)
          idq_pkg::OP_POP_BACK: begin
            count_nxt = count_r - ONE_CNT;
          end
          idq_pkg::OP_POP_FRONT: begin
            head_nxt  = head_r + ONE_PTR;
            count_nxt = count_r - ONE_CNT;
          end
          idq_pkg::OP_ERASE: begin
            if (idx_r == count_r - ONE_CNT) begin
              count_nxt = count_r - ONE_CNT;
            end else begin
              src_nxt   = idx_r + ONE_CNT;
              pend_nxt  = 1'b0;
              state_nxt = S_SHIFT;
            end
          end
          default: begin
          end
        endcase
      end

      // one element moved per cycle: read source now, write previous source's word
      S_SHIFT: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = slot_of(head_r, src_r);
        if (pend_r) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pdst_r;
          ram_req.wdata = ram_rdata;
        end
        pend_nxt = 1'b1;
        if (op_r == idq_pkg::OP_INSERT) begin
          pdst_nxt = slot_of(head_r, src_r + ONE_CNT);
          src_nxt  = src_r - ONE_CNT;
          if (src_r == idx_r) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          pdst_nxt = slot_of(head_r, src_r - ONE_CNT);
          src_nxt  = src_r + ONE_CNT;
          if (src_r == count_r - ONE_CNT) begin
            state_nxt = S_DRAIN;
          end
        end
      end

      S_DRAIN: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pdst_r;
        ram_req.wdata = ram_rdata;
        pend_nxt      = 1'b0;
        if (op_r == idq_pkg::OP_INSERT) begin
          state_nxt = S_INSW;
        end else begin
          count_nxt = count_r - ONE_CNT;
          state_nxt = S_RESP;
        end
      end

      S_INSW: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = slot_of(head_r, idx_r);
        ram_req.wdata = val_r;
        count_nxt     = count_r + ONE_CNT;
        state_nxt     = S_RESP;
      end

      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    idx_r    <= idx_nxt;
    val_r    <= val_nxt;
    src_r    <= src_nxt;
    pdst_r   <= pdst_nxt;
    status_r <= status_nxt;
    data_r   <= data_nxt;
  end

endmodule

`default_nettype wire

### rtl/indexed_double_ended_queue_top.sv
// Top level of the indexed double-ended queue: sequencer, ring store RAM and
// output register. Uses idq_pkg, idq_ram, idq_ctrl.
//
//  channel | dir | beat content
//  in_     | in  | tuser: op; tdata: index, value
//  out_    | out | tuser: status; tdata: data, count, is_empty
//
// Push, append insert, clear and any error go straight to the response; pop,
// read and erase of the last element first wait for the registered RAM read.
// Insert before i < n and erase at i < n-1, with n held, run a shift loop;
// one element moves per cycle. Synchronous active-low reset empties the queue.
// A result waits in the output register while out_tready is low; the next
// item is taken once the result has moved into that register.
`default_nettype none

module indexed_double_ended_queue_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [idq_pkg::IN_TDATA_W-1:0]       in_tdata,   // index, value, zero pad
  input  wire logic [idq_pkg::OP_W-1:0]             in_tuser,   // op
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic      [idq_pkg::OUT_TDATA_W-1:0]      out_tdata,  // data, count, is_empty, pad
  output logic      [idq_pkg::STATUS_W-1:0]         out_tuser   // status
);

  logic                          res_valid;
  logic                          res_ready;
  idq_pkg::res_t                 res;
  idq_pkg::ram_req_t             ram_req;
  logic [idq_pkg::DATA_W-1:0]    ram_rdata;
  logic                          out_valid_r;
  idq_pkg::res_t                 out_res_r;

  idq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_index  (in_tdata[idq_pkg::CNT_W-1:0]),
    .in_value  (in_tdata[idq_pkg::CNT_W +: idq_pkg::VALUE_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  idq_ram #(
    .DEPTH (idq_pkg::CAPACITY),
    .WIDTH (idq_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = idq_pkg::OUT_TDATA_W'({out_res_r.is_empty, out_res_r.count,
                                             out_res_r.data});

  a_ready_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !res_valid)
    else $error("input ready while a result is pending");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == idq_pkg::ST_FULL) |->
      res.count == idq_pkg::CNT_W'(idq_pkg::CAPACITY))
    else $error("full status without full count");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == idq_pkg::ST_EMPTY) |-> res.is_empty)
    else $error("empty status with elements held");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res.count <= idq_pkg::CNT_W'(idq_pkg::CAPACITY))
    else $error("count beyond capacity");

endmodule

`default_nettype wire
